// ===== hdl/servo_pulse_ramp_generator_macros.svh =====
// Assertion macros shared by the servo pulse ramp generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SERVO_PULSE_RAMP_GENERATOR_MACROS_SVH
`define SERVO_PULSE_RAMP_GENERATOR_MACROS_SVH

// Clocked assertion, quiet while reset is held low
`define SPR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset
`define SPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/spr_pkg.sv =====
// Package for the servo pulse ramp generator: beat types, fixed-point
// constants, reciprocal constants and sequencer states. No dependencies.
`timescale 1ns / 1ps

package spr_pkg;

    // Fixed-point format of pulse widths (microseconds, Q12.8)
    localparam int FRAC_BITS = 8;
    localparam int PULSE_W   = 20;
    localparam int DUR_W     = 16;
    localparam int CHAN_W    = 2;
    localparam int CMP_W     = 13;
    localparam int TICK_W    = 12;
    localparam int RELOAD_W  = 16;
    localparam int STEP_W    = 16;
    localparam int GAPQ_W    = PULSE_W - 2;

    localparam logic [PULSE_W-1:0] PULSE_MIN  = PULSE_W'(500 << FRAC_BITS);
    localparam logic [PULSE_W-1:0] PULSE_STOP = PULSE_W'(1500 << FRAC_BITS);
    localparam logic [PULSE_W-1:0] PULSE_MAX  = PULSE_W'(2500 << FRAC_BITS);
    localparam logic [PULSE_W-1:0] SNAP_GAP   = PULSE_W'(5 << FRAC_BITS);

    localparam logic [RELOAD_W-1:0] RELOAD_RST = RELOAD_W'(19999);
    localparam logic [TICK_W-1:0]   TICK_MAX   = {TICK_W{1'b1}};

    // Move lasts while ticks*200 < travel_ms*11 (20 ms ticks, 10% margin)
    localparam int SCALE_W = 20;
    localparam logic [SCALE_W-1:0] TICK_SCALE = SCALE_W'(200);
    localparam logic [SCALE_W-1:0] DUR_SCALE  = SCALE_W'(11);

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // gap/20 = ((gap>>2) * ceil(2^21/5)) >> 21, exact for gap>>2 < 2^18
    localparam int RECIP5_SHIFT = 21;
    localparam logic [MUL_W-1:0] RECIP5 = MUL_W'(419431);

    // 20000 us << FRAC_BITS = 625 << (5 + FRAC_BITS)
    localparam int PERIOD_SHIFT = 5 + FRAC_BITS;
    localparam int QUOT_W       = 23;
    // x/625 = (x * ceil(2^32/625)) >> 32, exact for x < 2^23
    localparam int RECIP625_SHIFT = 32;
    localparam logic [MUL_W-1:0] RECIP625 = MUL_W'(6871948);

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [PULSE_W-1:0] target_pulse;
        logic [DUR_W-1:0]   travel_ms;
        logic [CHAN_W-1:0]  channel;
    } in_item_t;

    typedef struct packed {
        logic [CMP_W-1:0]   compare_value;
        logic [PULSE_W-1:0] pulse_now;
        logic [CHAN_W-1:0]  out_channel;
        logic               moving;
        logic               finished;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPD,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } seq_state_t;

endpackage

// ===== hdl/servo_pulse_ramp_generator.sv =====
// Servo pulse ramp generator: sequencer, move state and output register.
// Depends on spr_pkg, spr_mul, spr_ramp and servo_pulse_ramp_generator_macros.svh.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries start beats (load target pulse,
//   travel time and channel, restart from 1500 us) and tick beats (one 20 ms
//   PWM period). Every input beat yields exactly one result beat on
//   m_valid/m_ready/m_data: compare count, pulse width, channel, moving and
//   finished flags. cfg_wr_en/cfg_wr_data write the timer reload value.
//   Flow: s_ready is high only while the sequencer is idle; a new beat is
//   taken only once the last one has left ST_OUT. A beat that updates the
//   ramp passes ST_EVAL, ST_UPD, ST_MUL1, ST_MUL2 and ST_OUT in that order,
//   a beat that gives the stop compare skips ST_UPD. The one shared
//   multiplier is used in turn: 5% step (gap times reciprocal of 20), pulse
//   times reload, then times the reciprocal of 625, each product registered.
//   The result is loaded into the output register as ST_OUT is left.
//   Stall: a finished result waits in the output register; the next input
//   beat is accepted meanwhile, and the sequencer holds before its output
//   step until the register is free.
//   Reset (aresetn low, synchronous): pulse and goal to 1500 us, idle, reload
//   19999, no result pending.
`timescale 1ns / 1ps
`include "servo_pulse_ramp_generator_macros.svh"

module servo_pulse_ramp_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  spr_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output spr_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [spr_pkg::RELOAD_W-1:0]  cfg_wr_data
);

    spr_pkg::seq_state_t           state_reg, state_next;
    logic [spr_pkg::PULSE_W-1:0]   pulse_reg, pulse_next;
    logic [spr_pkg::PULSE_W-1:0]   goal_reg, goal_next;
    logic [spr_pkg::DUR_W-1:0]     dur_reg, dur_next;
    logic [spr_pkg::TICK_W-1:0]    tick_reg, tick_next;
    logic [spr_pkg::CHAN_W-1:0]    chan_reg, chan_next;
    logic                          active_reg, active_next;
    logic                          fin_reg, fin_next;
    logic [spr_pkg::RELOAD_W-1:0]  reload_reg;
    logic                          m_valid_reg, m_valid_next;
    spr_pkg::out_item_t            m_data_reg, m_data_next;

    logic                          mul_en;
    logic [spr_pkg::MUL_W-1:0]     mul_a, mul_b;
    logic [spr_pkg::PROD_W-1:0]    prod;
    logic [spr_pkg::GAPQ_W-1:0]    gap_quarter;
    logic [spr_pkg::PULSE_W-1:0]   ramp_pulse;
    logic [spr_pkg::SCALE_W-1:0]   tick_scaled, dur_scaled;
    logic                          move_ok;
    logic                          out_free;

    // Shared multiplier
    spr_mul u_mul (
        .aclk   (aclk),
        .mul_en (mul_en),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .prod   (prod)
    );

    // Ramp step, fed with the registered 5% step
    spr_ramp u_ramp (
        .cur         (pulse_reg),
        .goal        (goal_reg),
        .step        (prod[spr_pkg::RECIP5_SHIFT +: spr_pkg::STEP_W]),
        .gap_quarter (gap_quarter),
        .pulse_next  (ramp_pulse)
    );

    // Move time check
    always_comb begin
        tick_scaled = spr_pkg::SCALE_W'(tick_reg) * spr_pkg::TICK_SCALE;
        dur_scaled  = spr_pkg::SCALE_W'(dur_reg) * spr_pkg::DUR_SCALE;
        move_ok     = tick_scaled < dur_scaled;
        out_free    = !m_valid_reg || m_ready;
    end

    // Sequencer: next state, state updates, multiplier operands
    always_comb begin
        state_next   = state_reg;
        pulse_next   = pulse_reg;
        goal_next    = goal_reg;
        dur_next     = dur_reg;
        tick_next    = tick_reg;
        chan_next    = chan_reg;
        active_next  = active_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            spr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == spr_pkg::ACT_START) begin
                        goal_next   = s_data.target_pulse;
                        dur_next    = s_data.travel_ms;
                        chan_next   = s_data.channel;
                        pulse_next  = spr_pkg::PULSE_STOP;
                        tick_next   = '0;
                        active_next = 1'b1;
                    end
                    state_next = spr_pkg::ST_EVAL;
                end
            end
            spr_pkg::ST_EVAL: begin
                fin_next = 1'b0;
                if (active_reg && move_ok) begin
                    mul_en     = 1'b1;
                    mul_a      = spr_pkg::MUL_W'(gap_quarter);
                    mul_b      = spr_pkg::RECIP5;
                    state_next = spr_pkg::ST_UPD;
                end else begin
                    if (active_reg) begin
                        active_next = 1'b0;
                        fin_next    = 1'b1;
                        pulse_next  = spr_pkg::PULSE_STOP;
                    end
                    state_next = spr_pkg::ST_MUL1;
                end
            end
            spr_pkg::ST_UPD: begin
                pulse_next = ramp_pulse;
                if (tick_reg < spr_pkg::TICK_MAX) begin
                    tick_next = tick_reg + 1'b1;
                end
                state_next = spr_pkg::ST_MUL1;
            end
            spr_pkg::ST_MUL1: begin
                mul_en     = 1'b1;
                mul_a      = spr_pkg::MUL_W'(pulse_reg);
                mul_b      = spr_pkg::MUL_W'(reload_reg);
                state_next = spr_pkg::ST_MUL2;
            end
            spr_pkg::ST_MUL2: begin
                mul_en     = 1'b1;
                mul_a      = spr_pkg::MUL_W'(prod[spr_pkg::PERIOD_SHIFT +: spr_pkg::QUOT_W]);
                mul_b      = spr_pkg::RECIP625;
                state_next = spr_pkg::ST_OUT;
            end
            spr_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.compare_value =
                        prod[spr_pkg::RECIP625_SHIFT +: spr_pkg::CMP_W];
                    m_data_next.pulse_now     = pulse_reg;
                    m_data_next.out_channel   = chan_reg;
                    m_data_next.moving        = active_reg;
                    m_data_next.finished      = fin_reg;
                    state_next                = spr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spr_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Move state, reload register and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg   <= spr_pkg::PULSE_STOP;
            goal_reg    <= spr_pkg::PULSE_STOP;
            dur_reg     <= '0;
            tick_reg    <= '0;
            chan_reg    <= '0;
            active_reg  <= 1'b0;
            fin_reg     <= 1'b0;
            reload_reg  <= spr_pkg::RELOAD_RST;
            m_valid_reg <= 1'b0;
        end else begin
            pulse_reg   <= pulse_next;
            goal_reg    <= goal_next;
            dur_reg     <= dur_next;
            tick_reg    <= tick_next;
            chan_reg    <= chan_next;
            active_reg  <= active_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                reload_reg <= cfg_wr_data;
            end
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == spr_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // One beat at a time: no second acceptance right after the first
    `SPR_ASSERT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted twice in a row")
    // The ramped pulse never leaves the servo range
    `SPR_ASSERT(a_pulse_range, aclk, aresetn, (pulse_reg >= spr_pkg::PULSE_MIN) && (pulse_reg <= spr_pkg::PULSE_MAX), "pulse out of range")
    // A finishing beat reports the stop pulse and no motion
    `SPR_ASSERT(a_finish_stop, aclk, aresetn, m_valid && m_data.finished |-> !m_data.moving && (m_data.pulse_now == spr_pkg::PULSE_STOP), "finish beat not at stop")
    // Reset drops any pending result
    `SPR_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result pending after reset")

endmodule

// ===== hdl/spr_mul.sv =====
// Shared multiplier of the ramp generator, product registered.
// Depends on spr_pkg for operand and product widths.
`timescale 1ns / 1ps

module spr_mul (
    input  logic                       aclk,
    input  logic                       mul_en,
    input  logic [spr_pkg::MUL_W-1:0]  op_a,
    input  logic [spr_pkg::MUL_W-1:0]  op_b,
    output logic [spr_pkg::PROD_W-1:0] prod
);

    logic [spr_pkg::PROD_W-1:0] prod_reg;

    // One multiply per enabled cycle
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= spr_pkg::PROD_W'(op_a) * spr_pkg::PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/spr_ramp.sv =====
// Ramp step logic: gap toward the goal, 5% move or snap, clamp to range.
// Depends on spr_pkg for pulse constants and widths.
`timescale 1ns / 1ps

module spr_ramp (
    input  logic [spr_pkg::PULSE_W-1:0] cur,
    input  logic [spr_pkg::PULSE_W-1:0] goal,
    input  logic [spr_pkg::STEP_W-1:0]  step,
    output logic [spr_pkg::GAPQ_W-1:0]  gap_quarter,
    output logic [spr_pkg::PULSE_W-1:0] pulse_next
);

    logic                        below;
    logic [spr_pkg::PULSE_W-1:0] gap;
    logic [spr_pkg::PULSE_W:0]   up_sum;
    logic [spr_pkg::PULSE_W-1:0] dn_diff;
    logic [spr_pkg::PULSE_W-1:0] moved;

    // Magnitude of the distance to the goal
    always_comb begin
        below       = cur < goal;
        gap         = below ? (goal - cur) : (cur - goal);
        gap_quarter = gap[spr_pkg::PULSE_W-1:2];
    end

    // Step toward the goal without overshoot, snap when close, then clamp
    always_comb begin
        up_sum  = (spr_pkg::PULSE_W + 1)'(cur) + (spr_pkg::PULSE_W + 1)'(step);
        dn_diff = cur - spr_pkg::PULSE_W'(step);
        if (gap <= spr_pkg::SNAP_GAP) begin
            moved = goal;
        end else if (below) begin
            moved = (up_sum > (spr_pkg::PULSE_W + 1)'(goal)) ? goal
                                                              : up_sum[spr_pkg::PULSE_W-1:0];
        end else begin
            moved = (dn_diff < goal) ? goal : dn_diff;
        end
        if (moved < spr_pkg::PULSE_MIN) begin
            pulse_next = spr_pkg::PULSE_MIN;
        end else if (moved > spr_pkg::PULSE_MAX) begin
            pulse_next = spr_pkg::PULSE_MAX;
        end else begin
            pulse_next = moved;
        end
    end

endmodule
